@@ hdl/cdq_pkg.sv @@
// Shared types and constants for the circular deque with dump.
// Used by the controller, the datapath and the top level; no dependencies.

package cdq_pkg;

    // Fixed widths of the request and result fields.
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // Command codes. Codes six and seven are not assigned and are ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP_FWD   = 3'd4,
        CMD_DUMP_BACK  = 3'd5
    } t_cmd;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming request
        logic exec;      // finish a push, pop or empty dump with one result
        logic dump_rd;   // read the store entry for the current dump step
        logic dump_out;  // emit the read entry as a result and advance
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_nop;     // captured command code is unassigned
        logic is_dump;    // captured command is a dump
        logic empty;      // deque holds no element
        logic slot_free;  // result register can take a new result this cycle
        logic idx_last;   // current dump step is the final element
    } t_dp_stat;

endpackage

@@ hdl/circular_deque_with_dump.sv @@
// Top level of the circular deque with dump: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath (which holds cdq_ram).
//
//  Channel   Direction  Handshake                   Payload
//  request   in         i_in_valid / o_in_ready     i_cmd, i_value
//  result    out        o_out_valid / i_out_ready   o_data, o_status, o_last
//
// A push, pop, empty dump or unassigned code is accepted in the idle state; the exec state then
// updates the front index, count and store and loads the result (an unassigned code
// loads none). A dump of a non-empty deque passes the accept and decode states, then for
// each element a store read and then the result load, for the registered read.
// Reset is synchronous and active low; it empties the deque with no store clearing pass.
// A stalled result holds in its register; the next request is still taken, then waits.

module circular_deque_with_dump #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [cdq_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [cdq_pkg::DATA_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [cdq_pkg::DATA_W-1:0]  o_data,
    output logic [cdq_pkg::STAT_W-1:0]         o_status,
    output logic                               o_last
);

    import cdq_pkg::*;

    t_ctrl_cmd ctl;
    t_dp_stat  stat;

    // Sequencing of each request.
    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // Deque state, store and result register.
    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

@@ hdl/cdq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cdq_datapath.sv @@
// Datapath of the circular deque: request registers, front index, element
// count, dump index, the element store and the result register.
// Depends on cdq_pkg and cdq_ram.

module cdq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [cdq_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [cdq_pkg::DATA_W-1:0]  i_value,
    input  cdq_pkg::t_ctrl_cmd                 i_ctl,
    output cdq_pkg::t_dp_stat                  o_stat,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [cdq_pkg::DATA_W-1:0]  o_data,
    output logic [cdq_pkg::STAT_W-1:0]         o_status,
    output logic                               o_last
);

    import cdq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;

    logic [CMD_W-1:0]  r_cmd;
    logic [DATA_W-1:0] r_value;
    logic [IW-1:0]     r_front;
    logic [IW-1:0]     n_front;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [IW-1:0]     r_idx;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_data;
    logic [STAT_W-1:0] r_status;
    logic              r_last;

    logic              is_push;
    logic              is_pop;
    logic              full;
    logic              empty;
    logic              slot_free;
    logic [IW-1:0]     front_dec;
    logic [IW-1:0]     front_inc;
    logic [IW-1:0]     back_pos;
    logic [CW-1:0]     dump_off;
    logic [IW-1:0]     dump_pos;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_rdata;

    // Ring position of the front index plus an offset below the depth.
    function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    // Decode of the captured request and the occupancy flags.
    assign is_push   = (r_cmd == CMD_PUSH_FRONT) || (r_cmd == CMD_PUSH_BACK);
    assign is_pop    = (r_cmd == CMD_POP_FRONT) || (r_cmd == CMD_POP_BACK);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign slot_free = !r_out_valid || i_out_ready;

    // Neighbor positions of the front index, wrapping at the depth.
    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign back_pos  = ring_pos(r_front, r_count);

    // Dump walks front to back, or back to front for a backward dump.
    assign dump_off = (r_cmd == CMD_DUMP_FWD) ? CW'(r_idx)
                                              : r_count - 1'b1 - CW'(r_idx);
    assign dump_pos = ring_pos(r_front, dump_off);

    // Store write for an accepted push.
    assign ram_we    = i_ctl.exec && is_push && !full;
    assign ram_waddr = (r_cmd == CMD_PUSH_FRONT) ? front_dec : back_pos;

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_re    (i_ctl.dump_rd),
        .i_raddr (dump_pos),
        .o_rdata (ram_rdata)
    );

    // Next front index and element count for push and pop.
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        if (i_ctl.exec) begin
            if (is_push && !full) begin
                n_count = r_count + 1'b1;
                if (r_cmd == CMD_PUSH_FRONT) begin
                    n_front = front_dec;
                end
            end else if (is_pop && !empty) begin
                n_count = r_count - 1'b1;
                if (r_cmd == CMD_POP_FRONT) begin
                    n_front = front_inc;
                end
            end
        end
    end

    // Deque state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Request capture; the dump index restarts with each request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_W'(CMD_PUSH_FRONT);
            r_idx <= '0;
        end else if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_idx <= '0;
        end else if (i_ctl.dump_out) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= i_value;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.exec || i_ctl.dump_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_data <= '0;
            r_last <= 1'b1;
            if (is_push) begin
                r_status <= full ? ST_FULL : ST_OK;
            end else if (is_pop) begin
                r_status <= empty ? ST_EMPTY : ST_OK;
            end else begin
                r_status <= ST_EMPTY;
            end
        end else if (i_ctl.dump_out) begin
            r_data   <= ram_rdata;
            r_status <= ST_OK;
            r_last   <= o_stat.idx_last;
        end
    end

    // Status to the controller.
    assign o_stat.is_nop    = !is_push && !is_pop && (r_cmd != CMD_DUMP_FWD)
                              && (r_cmd != CMD_DUMP_BACK);
    assign o_stat.is_dump   = (r_cmd == CMD_DUMP_FWD) || (r_cmd == CMD_DUMP_BACK);
    assign o_stat.empty     = empty;
    assign o_stat.slot_free = slot_free;
    assign o_stat.idx_last  = ((CW'(r_idx) + 1'b1) == r_count);

    assign o_out_valid = r_out_valid;
    assign o_data      = r_data;
    assign o_status    = r_status;
    assign o_last      = r_last;

    // The element count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above depth");

    // A push into a store that is not full adds exactly one element.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && is_push && !full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the count");

    // A new result is only loaded when the result register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec || i_ctl.dump_out) |-> slot_free)
        else $error("result register overwritten");

    // The front index stays inside the ring.
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_front) < SW'(DEPTH))
        else $error("front index outside ring");

endmodule

@@ hdl/cdq_ctrl.sv @@
// Controller state machine of the circular deque: accepts a request,
// sequences push, pop and empty-dump completion and the read/emit steps of a dump.
// Depends on cdq_pkg.

module cdq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cdq_pkg::t_dp_stat  i_stat,
    output cdq_pkg::t_ctrl_cmd o_ctl
);

    import cdq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_nop) begin
                    n_state = S_IDLE;
                end else if (i_stat.is_dump && !i_stat.empty) begin
                    n_state = S_DUMP_RD;
                end else if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_stat.slot_free) begin
                    n_state = i_stat.idx_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            S_EXEC: begin
                o_ctl.exec = !i_stat.is_nop && !(i_stat.is_dump && !i_stat.empty)
                             && i_stat.slot_free;
            end
            S_DUMP_RD: begin
                o_ctl.dump_rd = 1'b1;
            end
            S_DUMP_OUT: begin
                o_ctl.dump_out = i_stat.slot_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule
